// ===== rtl/core/spa_pkg.sv =====
// Shared types, codes and constants of the sparse polynomial adder.
package spa_pkg;

  // Store depth limit and payload widths
  localparam int MAX_TERMS = 32;
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 16;
  localparam int KIND_W    = 2;
  localparam int SUM_W     = COEF_W + 1;

  // Input word kinds; the fourth code is ignored
  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_RUN    = 2'd2
  } spa_kind_t;

  // One stored term
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic        [EXP_W-1:0]  expo;
  } spa_term_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE
  } spa_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input word accepted this cycle
    logic start;  // run accepted: rewind read pointers
    logic read;   // read both store heads
    logic emit;   // load output register, advance pointers
  } spa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
    logic last;      // the word being merged ends the run
  } spa_sts_t;

endpackage

// ===== rtl/core/spa_if.sv =====
// Valid/ready channel interfaces for term input and merged result output.
interface spa_in_if import spa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [COEF_W-1:0] coefficient;
  logic [EXP_W-1:0]         exponent;

  modport source (output valid, kind, coefficient, exponent, input ready);
  modport sink   (input valid, kind, coefficient, exponent, output ready);
endinterface

interface spa_out_if import spa_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_coefficient;
  logic [EXP_W-1:0]        sum_exponent;
  logic                    last_term;
  logic                    empty_result;
  logic                    overflow;

  modport source (output valid, sum_coefficient, sum_exponent, last_term, empty_result,
                  overflow, input ready);
  modport sink   (input valid, sum_coefficient, sum_exponent, last_term, empty_result,
                  overflow, output ready);
endinterface

// ===== rtl/core/sparse_polynomial_adder_top.sv =====
// Top level of the sparse polynomial adder: controller plus datapath.
//
//   channel  dir  payload                                                  word
//   in       in   kind, coefficient, exponent                              load or run
//   out      out  sum_coefficient, sum_exponent, last_term, empty_result,  one merged term
//                 overflow
//
// A load word is taken back to back whenever no run is active.
// A run is accepted in IDLE; each merged term then takes a head read, then a
// compare/add into the output register, as the store reads are registered;
// an empty run gives one word. No input is taken during a run.
// A stalled output holds the merge step until the output register frees up.
// Synchronous reset clears counts, read pointers, drop flag, state and output valid.
module sparse_polynomial_adder_top import spa_pkg::*; #(
  parameter int MaxTerms = MAX_TERMS
) (
  input logic       clk,
  input logic       rst,
  spa_in_if.sink    in,
  spa_out_if.source out
);

  spa_cmd_t cmd;
  spa_sts_t sts;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_kind  (in.kind),
    .in_ready (in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spa_dpath #(
    .MaxTerms (MaxTerms)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in.kind),
    .in_coefficient      (in.coefficient),
    .in_exponent         (in.exponent),
    .out_valid           (out.valid),
    .out_ready           (out.ready),
    .out_sum_coefficient (out.sum_coefficient),
    .out_sum_exponent    (out.sum_exponent),
    .out_last_term       (out.last_term),
    .out_empty_result    (out.empty_result),
    .out_overflow        (out.overflow)
  );

endmodule

// ===== rtl/core/spa_ctrl.sv =====
// Sequencing state machine: load phase, then read/merge steps of a run.
module spa_ctrl import spa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [KIND_W-1:0]     in_kind,
  output logic                  in_ready,
  input  spa_sts_t              sts,
  output spa_cmd_t              cmd
);

  spa_state_t state, state_next;
  logic       run_req;

  assign run_req = in_valid && (in_kind == KIND_RUN);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (run_req) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (sts.out_free) state_next = sts.last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.take  = in_valid;
        cmd.start = run_req;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_MERGE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/spa_dpath.sv =====
// Term stores, counts, merge compare/add and the output register.
module spa_dpath import spa_pkg::*; #(
  parameter int MaxTerms = MAX_TERMS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spa_cmd_t                 cmd,
  output spa_sts_t                 sts,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [COEF_W-1:0] in_coefficient,
  input  logic [EXP_W-1:0]         in_exponent,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  out_sum_coefficient,
  output logic [EXP_W-1:0]         out_sum_exponent,
  output logic                     out_last_term,
  output logic                     out_empty_result,
  output logic                     out_overflow
);

  localparam int CNT_W = $clog2(MaxTerms + 1);
  localparam int IDX_W = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MaxTerms);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  spa_term_t        first_mem  [MaxTerms];
  spa_term_t        second_mem [MaxTerms];
  logic [CNT_W-1:0] first_count, second_count;
  logic [CNT_W-1:0] first_ptr, second_ptr;
  logic             dropped;
  spa_term_t        head_a, head_b;
  spa_term_t        in_term;

  logic             has_a, has_b, take_a, take_b;
  logic [CNT_W-1:0] first_ptr_next, second_ptr_next;
  logic signed [SUM_W-1:0] coef_a, coef_b, merged_coef;
  logic [EXP_W-1:0] merged_exp;

  assign in_term.coef = in_coefficient;
  assign in_term.expo = in_exponent;

  // Store writes at the fill counts
  always_ff @(posedge clk) begin
    if (cmd.take && in_kind == KIND_FIRST && first_count < FULL) begin
      first_mem[first_count[IDX_W-1:0]] <= in_term;
    end
    if (cmd.take && in_kind == KIND_SECOND && second_count < FULL) begin
      second_mem[second_count[IDX_W-1:0]] <= in_term;
    end
  end

  // Registered head reads
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      head_a <= first_mem[first_ptr[IDX_W-1:0]];
      head_b <= second_mem[second_ptr[IDX_W-1:0]];
    end
  end

  // Merge decision on the two heads
  always_comb begin
    has_a  = first_ptr < first_count;
    has_b  = second_ptr < second_count;
    take_a = has_a && (!has_b || head_a.expo >= head_b.expo);
    take_b = has_b && (!has_a || head_b.expo >= head_a.expo);
    coef_a = {head_a.coef[COEF_W-1], head_a.coef};
    coef_b = {head_b.coef[COEF_W-1], head_b.coef};
    if (take_a && take_b) begin
      merged_coef = coef_a + coef_b;
      merged_exp  = head_a.expo;
    end else if (take_a) begin
      merged_coef = coef_a;
      merged_exp  = head_a.expo;
    end else if (take_b) begin
      merged_coef = coef_b;
      merged_exp  = head_b.expo;
    end else begin
      merged_coef = '0;
      merged_exp  = '0;
    end
    first_ptr_next  = take_a ? first_ptr + ONE : first_ptr;
    second_ptr_next = take_b ? second_ptr + ONE : second_ptr;
  end

  assign sts.last     = (first_ptr_next >= first_count) && (second_ptr_next >= second_count);
  assign sts.out_free = !out_valid || out_ready;

  // Counts, drop flag and read pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      first_ptr    <= '0;
      second_ptr   <= '0;
    end else begin
      if (cmd.take && in_kind == KIND_FIRST) begin
        if (first_count < FULL) first_count <= first_count + ONE;
        else                    dropped     <= 1'b1;
      end
      if (cmd.take && in_kind == KIND_SECOND) begin
        if (second_count < FULL) second_count <= second_count + ONE;
        else                     dropped      <= 1'b1;
      end
      if (cmd.start) begin
        first_ptr  <= '0;
        second_ptr <= '0;
      end
      if (cmd.emit) begin
        first_ptr  <= first_ptr_next;
        second_ptr <= second_ptr_next;
        if (sts.last) begin
          first_count  <= '0;
          second_count <= '0;
          dropped      <= 1'b0;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum_coefficient <= merged_coef;
      out_sum_exponent    <= merged_exp;
      out_last_term       <= sts.last;
      out_empty_result    <= !has_a && !has_b;
      out_overflow        <= sts.last && dropped;
    end
  end

endmodule

// ===== rtl/core/spa_checker.sv =====
// Port-level checks of the sparse polynomial adder, bound to the top level.
module spa_checker import spa_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [KIND_W-1:0]       in_kind,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] sum_coefficient,
  input logic [EXP_W-1:0]        sum_exponent,
  input logic                    last_term,
  input logic                    empty_result,
  input logic                    overflow
);

  // A waiting result word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // Input is closed right after a run is accepted
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_RUN |=> !in_ready)
    else $error("input open during run");

  // Empty and overflow marks appear only on the final word
  a_marks_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (empty_result || overflow) |-> last_term)
    else $error("empty or overflow mark off the final word");

  // An empty run result is the zero term
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_result |-> sum_coefficient == '0 && sum_exponent == '0)
    else $error("empty result carries a nonzero term");

endmodule

bind sparse_polynomial_adder_top spa_checker u_spa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in.valid),
  .in_ready        (in.ready),
  .in_kind         (in.kind),
  .out_valid       (out.valid),
  .out_ready       (out.ready),
  .sum_coefficient (out.sum_coefficient),
  .sum_exponent    (out.sum_exponent),
  .last_term       (out.last_term),
  .empty_result    (out.empty_result),
  .overflow        (out.overflow)
);
